>>> rtl/arrd_pkg.sv
// Shared types and constants for the additive range draw generator.
`default_nettype none

package arrd_pkg;

  localparam int WORD_W      = 32;
  localparam int RING_WORDS  = 31;
  localparam int FRONT_POS   = 3;
  localparam int FILL_W      = $clog2(RING_WORDS);
  localparam int DIVIDEND_W  = WORD_W - 1;
  localparam int LCG_MUL_W   = 15;
  localparam int PROD_W      = WORD_W + LCG_MUL_W;

  localparam logic [LCG_MUL_W-1:0] LCG_MUL = 15'd16807;
  localparam logic [WORD_W-1:0]    LCG_MOD = 32'h7FFF_FFFF;

  // Command codes
  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_UNSEED = 2'd1;
  localparam logic [1:0] KIND_CLOCK  = 2'd2;
  localparam logic [1:0] KIND_DIRECT = 2'd3;

  // Register indexes
  localparam logic CFG_DEFAULT_SEED  = 1'b0;
  localparam logic CFG_SEED_EXPLICIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_WARM,
    ST_DRAW,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic shift;
    logic add;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/arrd_cell.sv
// One word cell of the rotating ring.
`default_nettype none

module arrd_cell (
  input  wire logic                         clk,
  input  wire arrd_pkg::cell_ctl_t          ctl,
  input  wire logic [arrd_pkg::WORD_W-1:0]  shift_in,
  input  wire logic [arrd_pkg::WORD_W-1:0]  add_in,
  output logic      [arrd_pkg::WORD_W-1:0]  word
);

  logic [arrd_pkg::WORD_W-1:0] addend;

  assign addend = ctl.add ? add_in : '0;

  // Take the neighbor's word, optionally summed with the rear word
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      word <= shift_in + addend;
    end
  end

endmodule

`default_nettype wire

>>> rtl/arrd_lcg.sv
// Seed word generator: multiply by 16807 and fold modulo 2^31-1.
`default_nettype none

module arrd_lcg (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic [arrd_pkg::WORD_W-1:0]  seed,
  input  wire logic                         mul,
  input  wire logic                         red,
  output logic      [arrd_pkg::WORD_W-1:0]  word
);

  logic [arrd_pkg::PROD_W-1:0] prod;
  logic [arrd_pkg::WORD_W-1:0] fold;
  logic [arrd_pkg::WORD_W-1:0] fold_sub;
  logic [arrd_pkg::WORD_W-1:0] reduced;

  // 2^31 is 1 modulo 2^31-1: add the high part into the low part
  assign fold = {1'b0, prod[arrd_pkg::WORD_W-2:0]}
              + arrd_pkg::WORD_W'(prod[arrd_pkg::PROD_W-1:arrd_pkg::WORD_W-1]);
  assign fold_sub = fold - arrd_pkg::LCG_MOD;
  assign reduced  = (fold >= arrd_pkg::LCG_MOD) ? fold_sub : fold;

  always_ff @(posedge clk) begin
    if (load) begin
      word <= (seed == '0) ? arrd_pkg::WORD_W'(1) : seed;
    end else if (red) begin
      word <= reduced;
    end
    if (mul) begin
      prod <= arrd_pkg::PROD_W'(word) * arrd_pkg::PROD_W'(arrd_pkg::LCG_MUL);
    end
  end

endmodule

`default_nettype wire

>>> rtl/arrd_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module arrd_rem (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [arrd_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [arrd_pkg::WORD_W-1:0]      divisor,
  output logic                                  done,
  output logic      [arrd_pkg::WORD_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(arrd_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(arrd_pkg::DIVIDEND_W - 1);

  logic                              run;
  logic [CNT_W-1:0]                  cnt;
  logic [arrd_pkg::DIVIDEND_W-1:0]   dvd;
  logic [arrd_pkg::WORD_W-1:0]       dsr;
  logic [arrd_pkg::WORD_W:0]         trial;
  logic [arrd_pkg::WORD_W:0]         diff;

  assign trial = {remainder, dvd[arrd_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (run) begin
      remainder <= diff[arrd_pkg::WORD_W] ? trial[arrd_pkg::WORD_W-1:0]
                                          : diff[arrd_pkg::WORD_W-1:0];
      dvd       <= {dvd[arrd_pkg::DIVIDEND_W-2:0], 1'b0};
    end
  end

`ifndef NO_ASSERTIONS
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    start |-> divisor != '0)
    else $error("remainder unit started with zero divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !run)
    else $error("remainder done while still running");
`endif

endmodule

`default_nettype wire

>>> rtl/additive_random_range_draw.sv
// Top level: additive lagged generator (lags 31 and 3) with range reduction.
// Draw on a seeded ring: done strobes once the 31-step remainder unit is done, or
// after the draw step alone for a full span. Seeding (kind 3, kind 2 if allowed,
// or a draw on an unseeded ring) fills the ring from the shared multiplier by
// multiply and reduce steps, then warms up. One item at a time; busy marks it.
// rst clears control state and control registers; ring words stay unknown until seeded.
// The receiver cannot stall: done is a one-cycle strobe with random_value.
`default_nettype none

module additive_random_range_draw #(
  parameter int WARMUP_STEPS = 310
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   kind,
  input  wire logic [31:0]  range_low,
  input  wire logic [31:0]  range_high,
  input  wire logic [31:0]  seed_value,
  output logic              done,
  output logic      [31:0]  random_value,
  input  wire logic         cfg_write,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int W = arrd_pkg::WORD_W;
  localparam int N = arrd_pkg::RING_WORDS;
  localparam int WARM_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;
  localparam logic [WARM_W-1:0] WARM_LAST =
    WARM_W'((WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0);
  localparam logic [arrd_pkg::FILL_W-1:0] FILL_LAST = arrd_pkg::FILL_W'(N - 1);

  arrd_pkg::state_t state, state_next;

  // Control registers
  logic                          seeded;
  logic                          clock_seed_taken;
  logic [W-1:0]                  default_seed;
  logic                          seed_explicit;
  logic                          pend;
  logic [arrd_pkg::FILL_W-1:0]   fill_cnt;
  logic [WARM_W-1:0]             warm_cnt;

  // Word registers of the accepted item
  logic [W-1:0]                  low;
  logic [W-1:0]                  span;

  // Decoded control
  logic          accept;
  logic          clock_seed;
  logic          lcg_load;
  logic [W-1:0]  lcg_seed;
  logic          lcg_mul;
  logic          lcg_red;
  logic [W-1:0]  lcg_word;
  logic          ring_load;
  logic          ring_adv;
  logic          rem_start;
  logic          rem_done;
  logic [W-1:0]  rem_value;
  logic          finish;
  arrd_pkg::state_t after_fill;
  arrd_pkg::state_t after_seed;

  // Ring datapath
  logic [W-1:0]                  cell_word [N];
  logic [W-1:0]                  sum;
  logic [arrd_pkg::DIVIDEND_W-1:0] draw_v;
  logic [W-1:0]                  draw_add;

  assign busy       = (state != arrd_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign clock_seed = accept && (kind == arrd_pkg::KIND_CLOCK)
                      && !seed_explicit && !clock_seed_taken;

  // The ring is kept rotated so rear sits in cell 0 and front in FRONT_POS:
  // one advance sums front and rear and rotates everything by one cell.
  assign sum      = cell_word[arrd_pkg::FRONT_POS] + cell_word[0];
  assign draw_v   = sum[W-1:1];
  assign draw_add = (state == arrd_pkg::ST_DIV) ? rem_value : {1'b0, draw_v};

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [W-1:0]        nbr;
    arrd_pkg::cell_ctl_t ctl;

    if (k == N - 1) begin : g_tail
      // Tail takes new seed words while filling, else wraps from the head
      assign nbr = ring_load ? lcg_word : cell_word[0];
    end else begin : g_body
      assign nbr = cell_word[k + 1];
    end

    assign ctl.shift = ring_load || ring_adv;
    assign ctl.add   = ring_adv && (k == arrd_pkg::FRONT_POS - 1);

    arrd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_in (nbr),
      .add_in   (cell_word[0]),
      .word     (cell_word[k])
    );
  end

  arrd_lcg u_lcg (
    .clk  (clk),
    .load (lcg_load),
    .seed (lcg_seed),
    .mul  (lcg_mul),
    .red  (lcg_red),
    .word (lcg_word)
  );

  arrd_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (draw_v),
    .divisor   (span),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // Next state and control decode
  always_comb begin
    state_next = state;
    lcg_load   = 1'b0;
    lcg_seed   = seed_value;
    lcg_mul    = 1'b0;
    lcg_red    = 1'b0;
    ring_load  = 1'b0;
    ring_adv   = 1'b0;
    rem_start  = 1'b0;
    finish     = 1'b0;
    after_seed = pend ? arrd_pkg::ST_DRAW : arrd_pkg::ST_IDLE;
    after_fill = (WARMUP_STEPS == 0) ? after_seed : arrd_pkg::ST_WARM;
    unique case (state)
      arrd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (kind)
            arrd_pkg::KIND_DRAW: begin
              if (seeded) begin
                state_next = arrd_pkg::ST_DRAW;
              end else begin
                lcg_load   = 1'b1;
                lcg_seed   = default_seed;
                state_next = arrd_pkg::ST_MUL;
              end
            end
            arrd_pkg::KIND_UNSEED: begin
              state_next = arrd_pkg::ST_IDLE;
            end
            arrd_pkg::KIND_CLOCK: begin
              if (clock_seed) begin
                lcg_load   = 1'b1;
                lcg_seed   = seed_value | W'(1);
                state_next = arrd_pkg::ST_MUL;
              end
            end
            arrd_pkg::KIND_DIRECT: begin
              lcg_load   = 1'b1;
              state_next = arrd_pkg::ST_MUL;
            end
            default: state_next = arrd_pkg::ST_IDLE;
          endcase
        end
      end
      arrd_pkg::ST_MUL: begin
        // Push the current seed word in and form the next product
        lcg_mul   = 1'b1;
        ring_load = 1'b1;
        state_next = (fill_cnt == FILL_LAST) ? after_fill : arrd_pkg::ST_RED;
      end
      arrd_pkg::ST_RED: begin
        lcg_red    = 1'b1;
        state_next = arrd_pkg::ST_MUL;
      end
      arrd_pkg::ST_WARM: begin
        ring_adv = 1'b1;
        if (warm_cnt == WARM_LAST) begin
          state_next = after_seed;
        end
      end
      arrd_pkg::ST_DRAW: begin
        ring_adv = 1'b1;
        if (span == '0) begin
          // Full 32-bit span: use the value unreduced
          finish     = 1'b1;
          state_next = arrd_pkg::ST_IDLE;
        end else begin
          rem_start  = 1'b1;
          state_next = arrd_pkg::ST_DIV;
        end
      end
      arrd_pkg::ST_DIV: begin
        if (rem_done) begin
          finish     = 1'b1;
          state_next = arrd_pkg::ST_IDLE;
        end
      end
      default: state_next = arrd_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= arrd_pkg::ST_IDLE;
      seeded           <= 1'b0;
      clock_seed_taken <= 1'b0;
      default_seed     <= W'(1);
      seed_explicit    <= 1'b0;
      pend             <= 1'b0;
      fill_cnt         <= '0;
      warm_cnt         <= '0;
      done             <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (cfg_write) begin
        unique case (cfg_index)
          arrd_pkg::CFG_DEFAULT_SEED: begin
            default_seed <= cfg_data;
            seeded       <= 1'b0;
          end
          arrd_pkg::CFG_SEED_EXPLICIT: begin
            seed_explicit <= cfg_data[0];
          end
          default: seed_explicit <= seed_explicit;
        endcase
      end
      if (accept) begin
        pend <= (kind == arrd_pkg::KIND_DRAW);
        if (kind == arrd_pkg::KIND_UNSEED) begin
          seeded <= 1'b0;
        end
      end
      if (clock_seed) begin
        clock_seed_taken <= 1'b1;
      end
      // Start of a seeding pass: mark seeded and restart the fill count
      if (lcg_load) begin
        seeded   <= 1'b1;
        fill_cnt <= '0;
      end else if (ring_load) begin
        fill_cnt <= fill_cnt + arrd_pkg::FILL_W'(1);
      end
      if (state == arrd_pkg::ST_WARM) begin
        warm_cnt <= warm_cnt + WARM_W'(1);
      end else begin
        warm_cnt <= '0;
      end
    end
  end

  // Item words and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      low  <= range_low;
      span <= range_high - range_low + W'(1);
    end
    if (finish) begin
      random_value <= low + draw_add;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_seeded: assert property (@(posedge clk) disable iff (rst)
    busy |-> seeded)
    else $error("working on an item with an unseeded ring");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == arrd_pkg::ST_DRAW || $past(state) == arrd_pkg::ST_DIV))
    else $error("result strobe outside a draw");

  a_seeded_draw: assert property (@(posedge clk) disable iff (rst)
    accept && kind == arrd_pkg::KIND_DRAW && seeded |=> state == arrd_pkg::ST_DRAW)
    else $error("seeded draw did not go straight to the draw step");
`endif

endmodule

`default_nettype wire

>>> tb/additive_random_range_draw_tb.sv
// Testbench for the additive range draw generator: queued driver, strobe monitor, predictor.
`default_nettype none

module additive_random_range_draw_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Generator constants, kept apart from the package so a bad package value shows up
  localparam int          WARMUP_STEPS  = 310;
  localparam int          RING_LEN      = 31;
  localparam logic [4:0]  FRONT_START   = 5'd3;
  localparam logic [63:0] MINSTD_MUL    = 64'd16807;
  localparam logic [63:0] MINSTD_MOD    = 64'd2147483647;
  // Longest silent item: seeding with warm-up plus a draw, with margin
  localparam int          SETTLE_CYCLES = 61 + WARMUP_STEPS + 34 + 64;
  localparam int          RANDOM_PHASES = 5;
  localparam int          PHASE_WORDS   = 250;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seed;
  } cmd_word_t;

  // DUT inputs start at known values
  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [1:0]  kind       = arrd_pkg::KIND_DRAW;
  logic [31:0] range_low  = '0;
  logic [31:0] range_high = '0;
  logic [31:0] seed_value = '0;
  logic        cfg_write  = 1'b0;
  logic        cfg_index  = arrd_pkg::CFG_DEFAULT_SEED;
  logic [31:0] cfg_data   = '0;
  logic        busy;
  logic        done;
  logic [31:0] random_value;

  additive_random_range_draw #(
    .WARMUP_STEPS(WARMUP_STEPS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .range_low   (range_low),
    .range_high  (range_high),
    .seed_value  (seed_value),
    .done        (done),
    .random_value(random_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every word a reseed plus a draw)
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: ring, indices, flags and its own copy of the registers
  // ---------------------------------------------------------------------------
  logic [31:0] ring [RING_LEN];
  logic [4:0]  front_pos;
  logic [4:0]  rear_pos;
  logic        ring_seeded;
  logic        clock_seed_done;
  logic [31:0] reg_default_seed;
  logic        reg_seed_explicit;

  logic [31:0] expected_draws [$];   // drawn values still owed by the block
  cmd_word_t   pending_words [$];    // command words not yet presented
  int          words_queued = 0;
  int          words_taken  = 0;
  int          fail_count   = 0;

  initial begin
    foreach (ring[i]) ring[i] = '0;
    front_pos         = FRONT_START;
    rear_pos          = 5'd0;
    ring_seeded       = 1'b0;
    clock_seed_done   = 1'b0;
    reg_default_seed  = 32'd1;
    reg_seed_explicit = 1'b0;
  end

  // Add rear word into front word, advance both indices, return the sum
  function automatic logic [31:0] ring_advance();
    logic [31:0] sum;
    sum             = ring[front_pos] + ring[rear_pos];
    ring[front_pos] = sum;
    front_pos       = (front_pos == RING_LEN - 1) ? 5'd0 : front_pos + 5'd1;
    rear_pos        = (rear_pos == RING_LEN - 1) ? 5'd0 : rear_pos + 5'd1;
    return sum;
  endfunction

  // Fill the ring from a seed by the multiplicative recurrence, then warm it up
  task automatic ring_seed(logic [31:0] seed);
    logic [63:0] prod;
    logic [31:0] discard;
    ring[0] = (seed == 32'd0) ? 32'd1 : seed;
    for (int n = 1; n < RING_LEN; n++) begin
      prod    = {32'd0, ring[n-1]} * MINSTD_MUL;
      ring[n] = 32'(prod % MINSTD_MOD);
    end
    front_pos   = FRONT_START;
    rear_pos    = 5'd0;
    ring_seeded = 1'b1;
    for (int n = 0; n < WARMUP_STEPS; n++) discard = ring_advance();
  endtask

  // Apply one accepted command word to the predictor
  task automatic predict_word(cmd_word_t w);
    logic [31:0] v;
    logic [31:0] span;
    case (w.kind)
      arrd_pkg::KIND_DRAW: begin
        if (!ring_seeded) ring_seed(reg_default_seed);
        v    = ring_advance() >> 1;
        span = w.hi - w.lo + 32'd1;
        // a span that wraps to zero means the full 32-bit range
        if (span != 32'd0) v = v % span;
        expected_draws.push_back(w.lo + v);
      end
      arrd_pkg::KIND_UNSEED: begin
        ring_seeded = 1'b0;
      end
      arrd_pkg::KIND_CLOCK: begin
        if (!reg_seed_explicit && !clock_seed_done) begin
          ring_seed(w.seed | 32'd1);
          clock_seed_done = 1'b1;
        end
      end
      default: begin
        ring_seed(w.seed);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued words, hold while busy, idle a random gap per word
  // ---------------------------------------------------------------------------
  cmd_word_t held;
  int        gap_left  = 0;
  bit        burst_run = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // the word on the ports was taken at this edge
        predict_word(held);
        words_taken++;
        // switch now and then between gap-free bursts and random idling
        if ($urandom_range(0, 39) == 0) burst_run = !burst_run;
        gap_left = burst_run ? 0 : $urandom_range(0, 14);
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (pending_words.size() != 0) begin
          held       = pending_words.pop_front();
          kind       <= held.kind;
          range_low  <= held.lo;
          range_high <= held.hi;
          seed_value <= held.seed;
          start      <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest expected draw
  // ---------------------------------------------------------------------------
  task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch (%s): expected %h, actual %h", what, want, got);
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && done) begin
      if (expected_draws.size() == 0) begin
        note_failure("unexpected result", 32'hx, random_value);
      end else begin
        want = expected_draws.pop_front();
        if (random_value !== want) note_failure("random_value", want, random_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [1:0] k, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] seed);
    cmd_word_t w;
    w = '{kind: k, lo: lo, hi: hi, seed: seed};
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Write one register at the next edge and mirror it in the predictor
  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == arrd_pkg::CFG_DEFAULT_SEED) begin
      reg_default_seed = data;
      ring_seeded      = 1'b0;
    end else begin
      reg_seed_explicit = data[0];
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every word is taken and every draw returned, then let silent items finish
  task automatic wait_drained();
    while (words_taken != words_queued || expected_draws.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Draw a range of one of several shapes
  task automatic make_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    int          k;
    a = $urandom();
    b = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: begin lo = a; hi = b; end
      3:       begin lo = a; hi = a + $urandom_range(0, 15); end
      4:       begin lo = 32'd0; hi = b; end
      5:       begin lo = a; hi = a - 32'd1; end                   // full span
      6: begin
        k  = $urandom_range(0, 31);
        lo = a;
        hi = a + ((32'd1 << k) - 32'd1);
      end
      7:       begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end // inverted
      8:       begin lo = pick_extreme(); hi = pick_extreme(); end
      default: begin lo = a; hi = a + 32'h7FFF_FFFE + $urandom_range(0, 3); end
    endcase
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return arrd_pkg::KIND_DRAW;
    if (r < 89) return arrd_pkg::KIND_UNSEED;
    if (r < 92) return arrd_pkg::KIND_CLOCK;
    return arrd_pkg::KIND_DIRECT;
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seed;
    logic [31:0] dseed;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values: first draw seeds itself from default seed 1
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);    // full span
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'h0000_0000, 32'h0);    // span of one
    push_word(arrd_pkg::KIND_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    push_word(arrd_pkg::KIND_DRAW, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);    // wraps to full span
    push_word(arrd_pkg::KIND_DRAW, 32'd100, 32'd10, 32'h0);                  // inverted range
    push_word(arrd_pkg::KIND_DRAW, 32'hFFFF_FF00, 32'h0000_0010, 32'h0);    // inverted, sum wraps
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0);
    push_word(arrd_pkg::KIND_DIRECT, 32'h0, 32'h0, 32'h0000_0000);           // zero seed acts as one
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'h0000_0001, 32'h0);
    push_word(arrd_pkg::KIND_DIRECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'h8000_0000, 32'h0);
    push_word(arrd_pkg::KIND_UNSEED, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_word(arrd_pkg::KIND_DRAW, 32'h1234_5678, 32'h1234_5687, 32'h0);    // reseeds from default
    wait_drained();

    // Explicit seed set, default seed zero: clock seeding must be ignored
    write_reg(arrd_pkg::CFG_SEED_EXPLICIT, 32'hFFFF_FFFF);
    write_reg(arrd_pkg::CFG_DEFAULT_SEED, 32'h0000_0000);
    end_writes();
    push_word(arrd_pkg::KIND_CLOCK, 32'h0, 32'h0, 32'h5555_5554);
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);    // seeds from zero default
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0003, 32'h0000_0009, 32'h0);
    wait_drained();

    // Clock seeding allowed once; upper data bits must not set the flag
    write_reg(arrd_pkg::CFG_SEED_EXPLICIT, 32'hFFFF_FFFE);
    write_reg(arrd_pkg::CFG_DEFAULT_SEED, 32'hFFFF_FFFF);
    end_writes();
    push_word(arrd_pkg::KIND_CLOCK, 32'h0, 32'h0, 32'hAAAA_AAAA);            // taken
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
    push_word(arrd_pkg::KIND_CLOCK, 32'h0, 32'h0, 32'h0000_0000);            // ignored
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0000, 32'h0000_FFFF, 32'h0);
    push_word(arrd_pkg::KIND_UNSEED, 32'h0, 32'h0, 32'h0);
    push_word(arrd_pkg::KIND_CLOCK, 32'h0, 32'h0, 32'h1357_9BDF);            // still ignored
    push_word(arrd_pkg::KIND_DRAW, 32'h0000_0001, 32'h0000_0000, 32'h0);    // full span, from default
    wait_drained();

    // Random phases, each with fresh register values
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       dseed = 32'h0000_0001;
        1:       dseed = 32'h0000_0000;
        2:       dseed = 32'hFFFF_FFFF;
        default: dseed = $urandom();
      endcase
      write_reg(arrd_pkg::CFG_DEFAULT_SEED, dseed);
      write_reg(arrd_pkg::CFG_SEED_EXPLICIT, {31'($urandom_range(0, 32'h7FFF_FFFF)), ph[0]});
      end_writes();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        make_range(lo, hi);
        seed = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom();
        push_word(pick_kind(), lo, hi, seed);
      end
      wait_drained();
    end

    fail_count += expected_draws.size();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/arrd_pkg.sv
rtl/arrd_cell.sv
rtl/arrd_lcg.sv
rtl/arrd_rem.sv
rtl/additive_random_range_draw.sv
tb/additive_random_range_draw_tb.sv
